/* src/cop_pkg.sv */
`default_nettype none

package cop_pkg;

   localparam int BYTE_W     = 8;
   localparam int FIELD_NUM_W = 3;
   localparam int WIDE_W     = 64;
   localparam int NARROW_W   = 32;
   localparam int DIGIT_W    = 4;

   localparam int REQ_DATA_W = 8;
   localparam int REC_W      = WIDE_W + BYTE_W + 1 + NARROW_W + NARROW_W + WIDE_W;
   localparam int RSP_DATA_W = ((REC_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - REC_W;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd2;

   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;

   localparam logic [FIELD_NUM_W-1:0] FIELD_TIME   = 3'd0;
   localparam logic [FIELD_NUM_W-1:0] FIELD_ACTION = 3'd1;
   localparam logic [FIELD_NUM_W-1:0] FIELD_SIDE   = 3'd2;
   localparam logic [FIELD_NUM_W-1:0] FIELD_PRICE  = 3'd3;
   localparam logic [FIELD_NUM_W-1:0] FIELD_SIZE   = 3'd4;
   localparam logic [FIELD_NUM_W-1:0] LAST_FIELD   = 3'd5;

   typedef struct packed {
      logic [FIELD_NUM_W-1:0] field_number;
      logic [WIDE_W-1:0]      time_acc;
      logic [BYTE_W-1:0]      action_char;
      logic                   bid_flag;
      logic [NARROW_W-1:0]    price_acc;
      logic                   price_neg;
      logic [NARROW_W-1:0]    size_acc;
      logic [WIDE_W-1:0]      id_acc;
      logic                   started;
      logic                   closed;
      logic                   nonempty;
   } cop_line_type;

   function automatic logic [WIDE_W-1:0] times_ten_wide(input logic [WIDE_W-1:0] v,
                                                        input logic [DIGIT_W-1:0] d);
      times_ten_wide = (v << 3) + (v << 1) + {{(WIDE_W-DIGIT_W){1'b0}}, d};
   endfunction

   function automatic logic [NARROW_W-1:0] times_ten_narrow(input logic [NARROW_W-1:0] v,
                                                            input logic [DIGIT_W-1:0] d);
      times_ten_narrow = (v << 3) + (v << 1) + {{(NARROW_W-DIGIT_W){1'b0}}, d};
   endfunction

endpackage

`default_nettype wire

/* src/csv_order_record_parser.sv */
`default_nettype none

// Parses a comma-separated order file arriving one byte per word on req and
// returns one record per non-empty line on rsp. The configured number of
// header lines is skipped first; req_tlast marks the final byte of a file,
// flushes an unterminated last line and rearms the header skip for the next
// file. Writing csr_wdata sets the header line count and restarts the file.
// One byte is accepted per cycle while req_tready is high; the combinational
// line update's widest step is the 64-bit multiply-by-ten shift-add of the
// open numeric field. Records pass through a two-entry output buffer, so
// req_tready drops only while both entries hold records that rsp has not taken.
module csv_order_record_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [cop_pkg::BYTE_W-1:0]      csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // byte_req
   input  wire logic [cop_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // timestamp, action, is_bid, price, quantity, order_id, zero padding
   output logic [cop_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import cop_pkg::*;

   logic [BYTE_W-1:0]     hdr_ff, hdr_in;
   logic [BYTE_W-1:0]     skip_ff, skip_in;
   cop_line_type          line_ff, line_in, upd;
   logic [RSP_DATA_W-1:0] out_ff, out_in, skid_ff, skid_in;
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic [BYTE_W-1:0]     b;
   logic [DIGIT_W-1:0]    digit_val;
   logic                  is_digit, is_nl, in_data, line_done, accept, emit, produce, pop;
   logic [NARROW_W-1:0]   price_out;
   logic [RSP_DATA_W-1:0] rec_new;

   assign b         = req_tdata[BYTE_W-1:0];
   assign digit_val = b[DIGIT_W-1:0];
   assign is_digit  = (b >= CHAR_0) && (b <= CHAR_9);
   assign is_nl     = (b == CHAR_NL);
   assign in_data   = (skip_ff == '0);
   assign line_done = in_data && is_nl;
   assign accept    = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign pop        = out_valid_ff && rsp_tready;

   always_comb begin
      upd = line_ff;
      if (in_data && !is_nl) begin
         upd.nonempty = 1'b1;
         if (b == CHAR_COMMA && line_ff.field_number < LAST_FIELD) begin
            upd.field_number = line_ff.field_number + 3'd1;
            upd.started      = 1'b0;
            upd.closed       = 1'b0;
         end else begin
            case (line_ff.field_number)
               FIELD_ACTION: begin
                  if (!line_ff.started) upd.action_char = b;
               end
               FIELD_SIDE: begin
                  if (!line_ff.started) upd.bid_flag = (b == CHAR_B);
               end
               default: begin
                  if (!line_ff.closed) begin
                     if (is_digit) begin
                        case (line_ff.field_number)
                           FIELD_TIME: begin
                              upd.time_acc = times_ten_wide(line_ff.time_acc, digit_val);
                           end
                           FIELD_PRICE: begin
                              upd.price_acc = times_ten_narrow(line_ff.price_acc, digit_val);
                           end
                           FIELD_SIZE: begin
                              upd.size_acc = times_ten_narrow(line_ff.size_acc, digit_val);
                           end
                           default: begin
                              upd.id_acc = times_ten_wide(line_ff.id_acc, digit_val);
                           end
                        endcase
                     end else if (line_ff.field_number == FIELD_PRICE && !line_ff.started &&
                                  (b == CHAR_MINUS || b == CHAR_PLUS)) begin
                        upd.price_neg = (b == CHAR_MINUS);
                     end else begin
                        upd.closed = 1'b1;
                     end
                  end
               end
            endcase
            upd.started = 1'b1;
         end
      end
   end

   assign emit      = upd.nonempty && (req_tlast || line_done);
   assign produce   = accept && emit;
   assign price_out = upd.price_neg ? (NARROW_W'(0) - upd.price_acc) : upd.price_acc;
   assign rec_new   = {{RSP_PAD_W{1'b0}}, upd.id_acc, upd.size_acc, price_out,
                       upd.bid_flag, upd.action_char, upd.time_acc};

   always_comb begin
      hdr_in  = hdr_ff;
      skip_in = skip_ff;
      line_in = line_ff;
      if (csr_we) begin
         hdr_in  = csr_wdata;
         skip_in = csr_wdata;
         line_in = '0;
      end else if (accept) begin
         line_in = (req_tlast || line_done) ? '0 : upd;
         if (req_tlast) begin
            skip_in = hdr_ff;
         end else if (!in_data && is_nl) begin
            skip_in = skip_ff - 8'd1;
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rec_new;
            out_valid_in = produce;
         end
      end else if (produce) begin
         if (!out_valid_ff) begin
            out_in       = rec_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rec_new;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff        <= HEADER_RESET;
         skip_ff       <= HEADER_RESET;
         line_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         hdr_ff        <= hdr_in;
         skip_ff       <= skip_in;
         line_ff       <= line_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry holds a record while the output entry is empty.");

   a_header_line_empty: assert property (@(posedge clock) disable iff (reset)
      (skip_ff != '0) |-> !line_ff.nonempty)
      else $error("Line state is not empty while header lines are being skipped.");

   a_field_in_range: assert property (@(posedge clock) disable iff (reset)
      line_ff.field_number <= LAST_FIELD)
      else $error("Field number ran past the last field.");

   a_stalled_record_kept: assert property (@(posedge clock) disable iff (reset)
      (produce && out_valid_ff && !rsp_tready && !csr_we) |=> skid_valid_ff)
      else $error("A record produced behind a stalled output was dropped.");

endmodule

`default_nettype wire
